FILE: src/sbm_pkg.sv
// Shared types, constants and arithmetic helpers of the separable box mean filter.
`default_nettype none
package sbm_pkg;

	// Default sizing of the block.
	localparam int DEF_MAX_WIDTH    = 1024;
	localparam int DEF_MAX_RADIUS   = 7;
	localparam int DEF_MAX_CHANNELS = 4;

	// Fixed internal field widths, sized for the largest legal parameters.
	localparam int COL_BITS   = 13;
	localparam int ROW_BITS   = 16;
	localparam int WDT_BITS   = 14;
	localparam int MOD_BITS   = 4;
	localparam int POS_BITS   = 18;
	localparam int SUM_BITS   = 12;
	localparam int CFG_DW     = 16;
	localparam int JOBQ_DEPTH = 4;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_RADIUS   = 2'd2,
		REG_CHANNELS = 2'd3
	} reg_idx_t;

	// Input transaction payload.
	typedef struct packed {
		logic [7:0] in_chan0;
		logic [7:0] in_chan1;
		logic [7:0] in_chan2;
		logic [7:0] in_chan3;
	} in_pix_t;

	// Output transaction payload.
	typedef struct packed {
		logic [9:0]  out_col;
		logic [15:0] out_row;
		logic [7:0]  out_chan0;
		logic [7:0]  out_chan1;
		logic [7:0]  out_chan2;
		logic [7:0]  out_chan3;
		logic        last_of_run;
	} out_res_t;

	// Effective configuration after clamping.
	typedef struct packed {
		logic [WDT_BITS-1:0] w;
		logic [ROW_BITS-1:0] h;
		logic [2:0]          r;
		logic [2:0]          nch;
	} cfg_eff_t;

	// One classified pixel handed from the front to the back.
	typedef struct packed {
		logic [31:0]         pix;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		logic [MOD_BITS-1:0] cm;
		logic [MOD_BITS-1:0] rm;
		logic                x_any;
		logic                x_end;
		logic                y_any;
		logic                y_end;
	} job_t;

	// Increment modulo a window depth, given the last index of the window.
	function automatic logic [MOD_BITS-1:0] mod_inc(input logic [MOD_BITS-1:0] m,
		input logic [MOD_BITS-1:0] last);
		return (m == last) ? '0 : m + 1'b1;
	endfunction

	// Rounded mean (sum + r) / (2r + 1) by a reciprocal multiply, exact for all sums.
	function automatic logic [7:0] mean_div(input logic [SUM_BITS-1:0] sum,
		input logic [2:0] r);
		logic [18:0]         rc;
		logic [SUM_BITS-1:0] n;
		logic [30:0]         prod;
		case (r)
			3'd0: rc = 19'd262144;
			3'd1: rc = 19'd87382;
			3'd2: rc = 19'd52429;
			3'd3: rc = 19'd37450;
			3'd4: rc = 19'd29128;
			3'd5: rc = 19'd23832;
			3'd6: rc = 19'd20165;
			3'd7: rc = 19'd17477;
			default: rc = 19'd262144;
		endcase
		n = sum + SUM_BITS'(r);
		prod = 31'(n) * 31'(rc);
		return prod[25:18];
	endfunction

endpackage
`default_nettype wire

FILE: src/sbm_fifo.sv
// Short queue of classified pixels between the front and the back.
`default_nettype none
module sbm_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sbm_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output sbm_pkg::job_t rdata
);
	import sbm_pkg::*;

	localparam int PW = $clog2(JOBQ_DEPTH);

	job_t          mem_q [JOBQ_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(JOBQ_DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/sbm_front.sv
// Front end: accepts pixels, tracks the raster position and classifies each pixel.
`default_nettype none
module sbm_front #(
	parameter int MAX_RADIUS = sbm_pkg::DEF_MAX_RADIUS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sbm_pkg::cfg_eff_t cfg,
	input  logic             restart,
	input  logic             in_valid,
	output logic             in_ready,
	input  sbm_pkg::in_pix_t in_data,
	input  logic             job_full,
	output logic             job_push,
	output sbm_pkg::job_t    job
);
	import sbm_pkg::*;

	localparam int WIN = 2 * MAX_RADIUS + 1;

	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [MOD_BITS-1:0] cm_q;
	logic [MOD_BITS-1:0] rm_q;
	logic [COL_BITS-1:0] wm1;
	logic [ROW_BITS-1:0] hm1;
	logic                col_last;
	logic                row_last;

	assign in_ready = !job_full;
	assign job_push = in_valid && in_ready;
	assign wm1      = COL_BITS'(cfg.w - 1'b1);
	assign hm1      = cfg.h - 1'b1;
	assign col_last = (col_q == wm1);
	assign row_last = (row_q == hm1);

	// Classify the pixel: which horizontal and vertical runs it completes.
	always_comb begin
		job.pix[7:0]   = in_data.in_chan0;
		job.pix[15:8]  = (cfg.nch >= 3'd2) ? in_data.in_chan1 : 8'd0;
		job.pix[23:16] = (cfg.nch >= 3'd3) ? in_data.in_chan2 : 8'd0;
		job.pix[31:24] = (cfg.nch >= 3'd4) ? in_data.in_chan3 : 8'd0;
		job.col        = col_q;
		job.row        = row_q;
		job.cm         = cm_q;
		job.rm         = rm_q;
		job.x_end      = col_last;
		job.x_any      = col_last || (col_q >= COL_BITS'(cfg.r));
		job.y_end      = row_last;
		job.y_any      = row_last || (row_q >= ROW_BITS'(cfg.r));
	end

	// Raster position of the next pixel; a configuration write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cm_q  <= '0;
			rm_q  <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			cm_q  <= '0;
			rm_q  <= '0;
		end else if (job_push) begin
			if (col_last) begin
				col_q <= '0;
				cm_q  <= '0;
				if (row_last) begin
					row_q <= '0;
					rm_q  <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					rm_q  <= mod_inc(rm_q, MOD_BITS'(WIN - 1));
				end
			end else begin
				col_q <= col_q + 1'b1;
				cm_q  <= mod_inc(cm_q, MOD_BITS'(WIN - 1));
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/sbm_back.sv
// Back end: horizontal and vertical box sums, rounding, line store and result register.
`default_nettype none
module sbm_back #(
	parameter int MAX_WIDTH  = sbm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = sbm_pkg::DEF_MAX_RADIUS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sbm_pkg::cfg_eff_t cfg,
	input  logic              job_valid,
	output logic              job_pop,
	input  sbm_pkg::job_t     job,
	output logic              out_valid,
	input  logic              out_ready,
	output sbm_pkg::out_res_t out_data
);
	import sbm_pkg::*;

	localparam int WIN = 2 * MAX_RADIUS + 1;
	localparam int MW  = $clog2(WIN);
	localparam int AW  = $clog2(WIN * MAX_WIDTH);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_LOAD  = 9'b000000010,
		S_HACC  = 9'b000000100,
		S_HDIV  = 9'b000001000,
		S_HWR   = 9'b000010000,
		S_VACC  = 9'b000100000,
		S_VLAST = 9'b001000000,
		S_VDIV  = 9'b010000000,
		S_VOUT  = 9'b100000000
	} state_t;

	state_t                     state_q;
	job_t                       job_q;
	logic [31:0]                win_q [WIN];
	logic [31:0]                line_mem [WIN * MAX_WIDTH];
	logic [31:0]                rdata_q;
	logic                       dv_q;
	logic [COL_BITS-1:0]        x_q;
	logic [ROW_BITS-1:0]        y_q;
	logic signed [POS_BITS-1:0] xs_p_q;
	logic [MOD_BITS-1:0]        xs_m_q;
	logic signed [POS_BITS-1:0] ys_p_q;
	logic [MOD_BITS-1:0]        ys_m_q;
	logic signed [POS_BITS-1:0] p_q;
	logic [MOD_BITS-1:0]        m_q;
	logic [3:0]                 t_q;
	logic [SUM_BITS-1:0]        acc_q [4];
	logic [31:0]                mean_q;
	logic                       ovalid_q;
	out_res_t                   odata_q;

	logic [3:0]                 k2;
	logic [MOD_BITS-1:0]        mlast;
	logic [WDT_BITS-1:0]        wm1;
	logic [ROW_BITS-1:0]        hm1;
	logic signed [POS_BITS-1:0] lim;
	logic [MOD_BITS-1:0]        m_nx;
	logic signed [POS_BITS-1:0] xs0_p;
	logic [MOD_BITS-1:0]        xs0_m;
	logic signed [POS_BITS-1:0] ys0_p;
	logic [MOD_BITS-1:0]        ys0_m;
	logic [MOD_BITS-1:0]        xs_m_nx;
	logic [MOD_BITS-1:0]        ys_m_nx;
	logic [COL_BITS-1:0]        xlo;
	logic                       x_done;
	logic                       y_done;
	logic                       load;
	logic [31:0]                term;
	logic [31:0]                mean_nx;
	logic [AW-1:0]              wr_addr;
	logic [AW-1:0]              rd_addr;
	logic signed [5:0]          dx;
	logic signed [5:0]          dy;

	assign k2      = {cfg.r, 1'b0};
	assign mlast   = MOD_BITS'(WIN - 1);
	assign wm1     = cfg.w - 1'b1;
	assign hm1     = cfg.h - 1'b1;
	assign job_pop = (state_q == S_IDLE) && job_valid;
	assign xlo     = job_q.col - COL_BITS'(cfg.r);
	assign x_done  = !job_q.x_end || (x_q == COL_BITS'(wm1));
	assign y_done  = !job_q.y_end || (y_q == hm1);
	assign load    = (state_q == S_VOUT) && (!ovalid_q || out_ready);

	// Start positions of the first box term, and their place in the circular rows.
	always_comb begin
		xs0_p = POS_BITS'(job_q.col) - POS_BITS'(k2);
		ys0_p = POS_BITS'(job_q.row) - POS_BITS'(k2);
		dx    = $signed({2'b00, job_q.cm}) - $signed({2'b00, k2});
		dy    = $signed({2'b00, job_q.rm}) - $signed({2'b00, k2});
		if (dx < 0) begin
			dx = dx + 6'(WIN);
		end
		if (dy < 0) begin
			dy = dy + 6'(WIN);
		end
		xs0_m   = xs0_p[POS_BITS-1] ? '0 : dx[MOD_BITS-1:0];
		ys0_m   = ys0_p[POS_BITS-1] ? '0 : dy[MOD_BITS-1:0];
		xs_m_nx = xs_p_q[POS_BITS-1] ? '0 : mod_inc(xs_m_q, mlast);
		ys_m_nx = ys_p_q[POS_BITS-1] ? '0 : mod_inc(ys_m_q, mlast);
	end

	// The clamped term position only moves while it lies inside the frame.
	always_comb begin
		lim  = (state_q == S_HACC) ? POS_BITS'(wm1) : POS_BITS'(hm1);
		m_nx = (!p_q[POS_BITS-1] && (p_q < lim)) ? mod_inc(m_q, mlast) : m_q;
	end

	// Term source, rounding and memory addresses.
	always_comb begin
		term = (state_q == S_HACC) ? win_q[m_q[MW-1:0]] : rdata_q;
		for (int ch = 0; ch < 4; ch++) begin
			mean_nx[8*ch +: 8] = mean_div(acc_q[ch], cfg.r);
		end
		if (cfg.nch == 3'd4) begin
			mean_nx[31:24] = 8'hFF;
		end
		wr_addr = AW'(MAX_WIDTH) * AW'(job_q.rm[MW-1:0]) + AW'(x_q);
		rd_addr = AW'(MAX_WIDTH) * AW'(m_q[MW-1:0]) + AW'(x_q);
	end

	// Pixel window of the current row.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			win_q[job_q.cm[MW-1:0]] <= job_q.pix;
		end
	end

	// Line store of horizontal means, one read port with registered data.
	always_ff @(posedge clk) begin
		if (state_q == S_HWR) begin
			line_mem[wr_addr] <= mean_q;
		end
		rdata_q <= line_mem[rd_addr];
	end

	// Sequencer for the horizontal run, then the vertical outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dv_q    <= 1'b0;
		end else begin
			dv_q <= (state_q == S_VACC);
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= job_q.x_any ? S_HACC : S_IDLE;
				end
				S_HACC: begin
					if (t_q == k2) begin
						state_q <= S_HDIV;
					end
				end
				S_HDIV: begin
					state_q <= S_HWR;
				end
				S_HWR: begin
					if (!x_done) begin
						state_q <= S_HACC;
					end else begin
						state_q <= job_q.y_any ? S_VACC : S_IDLE;
					end
				end
				S_VACC: begin
					if (t_q == k2) begin
						state_q <= S_VLAST;
					end
				end
				S_VLAST: begin
					state_q <= S_VDIV;
				end
				S_VDIV: begin
					state_q <= S_VOUT;
				end
				S_VOUT: begin
					if (load) begin
						state_q <= (x_done && y_done) ? S_IDLE : S_VACC;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					job_q <= job;
				end
			end
			S_LOAD: begin
				x_q    <= xlo;
				xs_p_q <= xs0_p;
				xs_m_q <= xs0_m;
				p_q    <= xs0_p;
				m_q    <= xs0_m;
				t_q    <= '0;
				for (int ch = 0; ch < 4; ch++) begin
					acc_q[ch] <= '0;
				end
			end
			S_HACC, S_VACC, S_VLAST: begin
				if (state_q == S_HACC || dv_q) begin
					for (int ch = 0; ch < 4; ch++) begin
						acc_q[ch] <= acc_q[ch] + SUM_BITS'(term[8*ch +: 8]);
					end
				end
				if (state_q != S_VLAST) begin
					t_q <= t_q + 1'b1;
					p_q <= p_q + 1'b1;
					m_q <= m_nx;
				end
			end
			S_HDIV, S_VDIV: begin
				mean_q <= mean_nx;
			end
			S_HWR: begin
				t_q <= '0;
				for (int ch = 0; ch < 4; ch++) begin
					acc_q[ch] <= '0;
				end
				if (!x_done) begin
					x_q    <= x_q + 1'b1;
					xs_p_q <= xs_p_q + 1'b1;
					xs_m_q <= xs_m_nx;
					p_q    <= xs_p_q + 1'b1;
					m_q    <= xs_m_nx;
				end else begin
					x_q    <= xlo;
					y_q    <= job_q.row - ROW_BITS'(cfg.r);
					ys_p_q <= ys0_p;
					ys_m_q <= ys0_m;
					p_q    <= ys0_p;
					m_q    <= ys0_m;
				end
			end
			S_VOUT: begin
				if (load) begin
					t_q <= '0;
					for (int ch = 0; ch < 4; ch++) begin
						acc_q[ch] <= '0;
					end
					if (!x_done) begin
						x_q <= x_q + 1'b1;
						p_q <= ys_p_q;
						m_q <= ys_m_q;
					end else begin
						x_q    <= xlo;
						y_q    <= y_q + 1'b1;
						ys_p_q <= ys_p_q + 1'b1;
						ys_m_q <= ys_m_nx;
						p_q    <= ys_p_q + 1'b1;
						m_q    <= ys_m_nx;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: the next result is computed while this one waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			odata_q.out_col     <= x_q[9:0];
			odata_q.out_row     <= y_q;
			odata_q.out_chan0   <= mean_q[7:0];
			odata_q.out_chan1   <= mean_q[15:8];
			odata_q.out_chan2   <= mean_q[23:16];
			odata_q.out_chan3   <= mean_q[31:24];
			odata_q.last_of_run <= x_done && y_done;
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	// The term counter never runs past the last box term.
	a_term_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HACC || state_q == S_VACC) |-> (t_q <= k2))
		else $error("box term counter overran the kernel");

	// The final vertical term always has read data waiting.
	a_last_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VLAST) |-> dv_q)
		else $error("line store data missing on the last term");

	// The circular row index stays inside the window.
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HACC || state_q == S_VACC) |-> (m_q <= mlast))
		else $error("window index out of range");

	// A result marked last of its run ends the work on that pixel.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && x_done && y_done) |=> (state_q == S_IDLE))
		else $error("sequencer kept running after the last result");

endmodule
`default_nettype wire

FILE: src/separable_box_mean_filter.sv
// Top level of the separable box mean filter: configuration registers and the two halves.
`default_nettype none
// Streaming box mean with edge replication over 1 to 4 channels of 8 bits. Pixels enter in
// raster order on the in_* transaction channel; each filtered pixel leaves with its column and
// row, and last_of_run marks the final result caused by one input pixel. A pixel that closes
// no horizontal run is only stored in the pixel window; one that closes a run writes one
// horizontal mean (or r+1 at the end of a row, with r the effective radius) and then any
// results that it causes, each horizontal and each vertical sum being gathered one term per
// cycle through the single read port of the pixel window and of the line store. A
// four-entry queue lets the input side keep accepting pixels while the back end works, and
// the result register lets the back end move on while a result waits. The line store holds
// (2*MAX_RADIUS+1)*MAX_WIDTH words, needs no clearing after reset, and every entry is
// written in a frame before it is read. Any configuration write restarts the frame at
// column 0, row 0; write only while the block is idle.
module separable_box_mean_filter #(
	parameter int MAX_WIDTH    = sbm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_RADIUS   = sbm_pkg::DEF_MAX_RADIUS,
	parameter int MAX_CHANNELS = sbm_pkg::DEF_MAX_CHANNELS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [sbm_pkg::CFG_DW-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  sbm_pkg::in_pix_t           in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output sbm_pkg::out_res_t          out_data
);
	import sbm_pkg::*;

	logic [10:0]         width_q;
	logic [15:0]         height_q;
	logic [2:0]          radius_q;
	logic [2:0]          chans_q;
	cfg_eff_t            cfg;
	logic [WDT_BITS-1:0] wm1;
	logic [ROW_BITS-1:0] hm1;
	logic                job_push;
	logic                job_full;
	logic                job_pop;
	logic                job_valid;
	job_t                job_in;
	job_t                job_out;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 16'd480;
			radius_q <= 3'd1;
			chans_q  <= 3'd3;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_WIDTH:    width_q  <= cfg_data[10:0];
				REG_HEIGHT:   height_q <= cfg_data[15:0];
				REG_RADIUS:   radius_q <= cfg_data[2:0];
				REG_CHANNELS: chans_q  <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the programmed values to what the hardware supports.
	always_comb begin
		cfg.w = WDT_BITS'(width_q);
		if (width_q == '0) begin
			cfg.w = WDT_BITS'(1);
		end else if (WDT_BITS'(width_q) > WDT_BITS'(MAX_WIDTH)) begin
			cfg.w = WDT_BITS'(MAX_WIDTH);
		end
		cfg.h = (height_q == '0) ? ROW_BITS'(1) : height_q;
		wm1   = cfg.w - 1'b1;
		hm1   = cfg.h - 1'b1;
		cfg.r = radius_q;
		if (WDT_BITS'(cfg.r) > wm1) begin
			cfg.r = wm1[2:0];
		end
		if (ROW_BITS'(cfg.r) > hm1) begin
			cfg.r = hm1[2:0];
		end
		if (cfg.r > 3'(MAX_RADIUS)) begin
			cfg.r = 3'(MAX_RADIUS);
		end
		cfg.nch = chans_q;
		if (chans_q == '0) begin
			cfg.nch = 3'd1;
		end else if (chans_q > 3'(MAX_CHANNELS)) begin
			cfg.nch = 3'(MAX_CHANNELS);
		end
	end

	sbm_front #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (cfg_we),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.job_full(job_full),
		.job_push(job_push),
		.job     (job_in)
	);

	sbm_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (job_in),
		.full  (job_full),
		.pop   (job_pop),
		.valid (job_valid),
		.rdata (job_out)
	);

	sbm_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job      (job_out),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

FILE: verif/separable_box_mean_filter_test.sv
// Self-checking testbench of the separable box mean filter with its own pixel-level predictor.
module separable_box_mean_filter_test;
	import sbm_pkg::*;

	localparam int LINE_MAX     = 1024;
	localparam int WIN          = 15;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int SETTLE       = 1000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = REG_WIDTH;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_pix_t           in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_res_t          out_data;

	separable_box_mean_filter i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #6 clk = ~clk;

	// Predictor state: registers, row window, line store and raster position.
	logic [10:0] cur_width  = 11'd640;
	logic [15:0] cur_height = 16'd480;
	logic [2:0]  cur_radius = 3'd1;
	logic [2:0]  cur_chans  = 3'd3;
	logic [31:0] row_win [WIN];
	logic [31:0] hmean_store [WIN][LINE_MAX];
	int          pos_col = 0;
	int          pos_row = 0;

	out_res_t    expected_pixels[$];
	int          fail_count = 0;
	int          result_count = 0;
	int          pixel_count = 0;
	int          setting_count = 0;
	bit          idle_on = 1'b1;
	int          ready_hold = 0;
	int          cycle_count = 0;

	initial begin
		foreach (row_win[i]) row_win[i] = '0;
		foreach (hmean_store[i, j]) hmean_store[i][j] = '0;
	end

	function automatic int clampi(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Rounded means of up to four channel sums, alpha forced with four channels.
	function automatic logic [31:0] round_means(int s[4], int r, int nch);
		logic [31:0] res;
		res = '0;
		for (int ch = 0; ch < nch; ch++)
			res[8*ch +: 8] = 8'((s[ch] + r) / (2 * r + 1));
		if (nch == 4)
			res[31:24] = 8'hFF;
		return res;
	endfunction

	// Work out the filtered pixels that one accepted input pixel releases.
	task automatic predict_pixel(in_pix_t p);
		int w, h, r, nch, c, row, xlo, xhi, ylo, yhi, n;
		int s[4];
		logic [7:0] chv[4];
		logic [31:0] pix, v;
		out_res_t res;
		w = (cur_width < 1) ? 1 : ((cur_width > LINE_MAX) ? LINE_MAX : int'(cur_width));
		h = (cur_height < 1) ? 1 : int'(cur_height);
		r = cur_radius;
		if (r > w - 1) r = w - 1;
		if (r > h - 1) r = h - 1;
		nch = (cur_chans < 1) ? 1 : ((cur_chans > 4) ? 4 : int'(cur_chans));
		c = (pos_col >= w) ? 0 : pos_col;
		row = (pos_row >= h) ? 0 : pos_row;
		chv = '{p.in_chan0, p.in_chan1, p.in_chan2, p.in_chan3};
		pix = '0;
		for (int ch = 0; ch < nch; ch++)
			pix[8*ch +: 8] = chv[ch];
		row_win[c % WIN] = pix;

		if (c == w - 1) begin
			xlo = w - 1 - r; xhi = w - 1;
		end else if (c >= r) begin
			xlo = c - r; xhi = c - r;
		end else begin
			xlo = 1; xhi = 0;
		end
		// Horizontal pass into the line store.
		for (int x = xlo; x <= xhi; x++) begin
			s = '{0, 0, 0, 0};
			for (int k = -r; k <= r; k++)
				for (int ch = 0; ch < nch; ch++)
					s[ch] += row_win[clampi(x + k, 0, w - 1) % WIN][8*ch +: 8];
			hmean_store[row % WIN][x] = round_means(s, r, nch);
		end

		if (row == h - 1) begin
			ylo = h - 1 - r; yhi = h - 1;
		end else if (row >= r) begin
			ylo = row - r; yhi = row - r;
		end else begin
			ylo = 1; yhi = 0;
		end
		// Vertical pass, results in row-major order.
		n = 0;
		for (int y = ylo; y <= yhi; y++)
			for (int x = xlo; x <= xhi; x++) begin
				s = '{0, 0, 0, 0};
				for (int k = -r; k <= r; k++)
					for (int ch = 0; ch < nch; ch++)
						s[ch] += hmean_store[clampi(y + k, 0, h - 1) % WIN][x][8*ch +: 8];
				v = round_means(s, r, nch);
				res.out_col = 10'(x);
				res.out_row = 16'(y);
				res.out_chan0 = v[7:0];
				res.out_chan1 = v[15:8];
				res.out_chan2 = v[23:16];
				res.out_chan3 = v[31:24];
				res.last_of_run = 1'b0;
				expected_pixels.push_back(res);
				n++;
			end
		if (n > 0)
			expected_pixels[expected_pixels.size() - 1].last_of_run = 1'b1;

		c++;
		if (c >= w) begin
			c = 0;
			row++;
			if (row >= h) row = 0;
		end
		pos_col = c;
		pos_row = row;
	endtask

	// Send one pixel transaction and predict once it is accepted.
	task automatic send_pixel(in_pix_t p);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_pixel(p);
		pixel_count++;
	endtask

	// Wait until every expected result has come and the back end has drained.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH:    cur_width  = val[10:0];
			REG_HEIGHT:   cur_height = val[15:0];
			REG_RADIUS:   cur_radius = val[2:0];
			REG_CHANNELS: cur_chans  = val[2:0];
			default: ;
		endcase
		pos_col = 0;
		pos_row = 0;
	endtask

	task automatic set_frame(int w, int h, int r, int nch);
		wait_idle();
		write_reg(REG_WIDTH, CFG_DW'(w));
		write_reg(REG_HEIGHT, CFG_DW'(h));
		write_reg(REG_RADIUS, CFG_DW'(r));
		write_reg(REG_CHANNELS, CFG_DW'(nch));
		setting_count++;
	endtask

	function automatic in_pix_t rand_pixel();
		in_pix_t p;
		p = in_pix_t'($urandom);
		// Push some pixels to the extremes of the range.
		if ($urandom_range(0, 7) == 0)
			p = $urandom_range(0, 1) ? '1 : '0;
		return p;
	endfunction

	task automatic send_frame(int count);
		for (int i = 0; i < count; i++)
			send_pixel(rand_pixel());
	endtask

	// Extremes of the pixel values on the smallest frames and both ends of the radius.
	task automatic test_value_extremes();
		set_frame(2, 2, 7, 4);
		send_pixel('1); send_pixel('0); send_pixel('0); send_pixel('1);
		set_frame(3, 3, 1, 1);
		for (int i = 0; i < 9; i++)
			send_pixel((i % 2) ? in_pix_t'(32'hFFFFFFFF) : in_pix_t'(32'h00000000));
		set_frame(3, 2, 0, 2);
		send_pixel(32'hFF00FF00); send_pixel(32'h00FF00FF); send_pixel(32'h80808080);
		send_pixel(32'h7F7F7F7F); send_pixel(32'h01FE01FE); send_pixel(32'hFE01FE01);
	endtask

	// Degenerate register values that the block clamps.
	task automatic test_clamped_settings();
		set_frame(0, 3, 3, 3);
		send_frame(3);
		set_frame(1, 2, 2, 0);
		send_frame(2);
		set_frame(4, 0, 2, 7);
		send_frame(4);
		set_frame(2, 2, 1, 5);
		send_frame(4);
		// A write in the middle of a frame starts a new one.
		set_frame(5, 4, 2, 3);
		send_frame(7);
		set_frame(5, 4, 2, 3);
		send_frame(20);
	endtask

	// Register values at the widest and tallest limits.
	task automatic test_large_sizes();
		set_frame(1024, 2, 7, 4);
		send_frame(20);
		set_frame(2047, 0, 7, 3);
		send_frame(20);
		set_frame(4, 65535, 7, 2);
		send_frame(20);
	endtask

	// Largest burst of results: a full radius seven frame.
	task automatic test_full_radius();
		set_frame(16, 8, 7, 4);
		send_frame(128);
	endtask

	// Random small frames, mostly complete, some cut short by a new setting.
	task automatic test_random_frames();
		int w, h, n, budget;
		budget = 110;
		while (budget > 0) begin
			w = $urandom_range(2, 20);
			h = $urandom_range(2, 12);
			idle_on = ($urandom_range(0, 3) != 0);
			set_frame(w, h, $urandom_range(0, 7), $urandom_range(0, 7));
			n = w * h;
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, n);
			if (n > budget)
				n = budget;
			send_frame(n);
			budget -= n;
		end
		idle_on = 1'b1;
	endtask

	// Result side: random stalls between transactions.
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			out_ready <= 1'b0;
			ready_hold--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare every result transaction with the oldest expected pixel.
	always @(posedge clk) begin
		out_res_t want;
		if (arst_n && out_valid && out_ready) begin
			ready_hold = idle_on ? $urandom_range(0, 3) : 0;
			result_count++;
			if (expected_pixels.size() == 0) begin
				$error("unexpected result col %0d row %0d", out_data.out_col, out_data.out_row);
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (out_data.out_col !== want.out_col) begin
					$error("out_col expected %0d actual %0d", want.out_col, out_data.out_col);
					fail_count++;
				end
				if (out_data.out_row !== want.out_row) begin
					$error("out_row expected %0d actual %0d", want.out_row, out_data.out_row);
					fail_count++;
				end
				if (out_data.out_chan0 !== want.out_chan0) begin
					$error("out_chan0 expected %0d actual %0d", want.out_chan0, out_data.out_chan0);
					fail_count++;
				end
				if (out_data.out_chan1 !== want.out_chan1) begin
					$error("out_chan1 expected %0d actual %0d", want.out_chan1, out_data.out_chan1);
					fail_count++;
				end
				if (out_data.out_chan2 !== want.out_chan2) begin
					$error("out_chan2 expected %0d actual %0d", want.out_chan2, out_data.out_chan2);
					fail_count++;
				end
				if (out_data.out_chan3 !== want.out_chan3) begin
					$error("out_chan3 expected %0d actual %0d", want.out_chan3, out_data.out_chan3);
					fail_count++;
				end
				if (out_data.last_of_run !== want.last_of_run) begin
					$error("last_of_run expected %0d actual %0d", want.last_of_run,
						out_data.last_of_run);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("separable_box_mean_filter_test: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_value_extremes();
		test_clamped_settings();
		test_large_sizes();
		test_full_radius();
		test_random_frames();
		wait_idle();
		if (expected_pixels.size() > 0) begin
			$error("%0d expected results never arrived", expected_pixels.size());
			fail_count++;
		end
		$display("Sent %0d pixels over %0d register settings, checked %0d filtered pixels.",
			pixel_count, setting_count, result_count);
		if (fail_count == 0) begin
			$display("separable_box_mean_filter_test: PASS");
		end else begin
			$display("separable_box_mean_filter_test: FAIL");
		end
		$finish;
	end

endmodule
